@@ rtl/ippf_pkg.sv @@
// Shared types and constants for the IPv4 protocol/port frame filter.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package ippf_pkg;

    localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
    localparam logic [9:0]  MAX_MATCH_COUNT = 10'd1000;

    localparam logic [15:0] IPV4_ETHERTYPE  = 16'h0800;
    localparam logic [15:0] MIN_FRAME_LEN   = 16'd34;
    localparam logic [6:0]  ETH_HDR_LEN     = 7'd14;

    localparam logic [15:0] OFS_TYPE_HI     = 16'd12;
    localparam logic [15:0] OFS_TYPE_LO     = 16'd13;
    localparam logic [15:0] OFS_IHL         = 16'd14;
    localparam logic [15:0] OFS_PROTOCOL    = 16'd23;

    localparam int unsigned CFG_INDEX_W     = 8;
    localparam int unsigned CFG_DATA_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PORT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_GOAL = 8'd2;

    // Frame fields as they stand after the last byte of a frame.
    typedef struct packed {
        logic [15:0] length;
        logic [6:0]  port_ofs;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_frame_info;

    typedef struct packed {
        logic        matched;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] frame_length;
        logic [9:0]  match_count;
        logic        done_res;
    } t_result;

    typedef struct packed {
        logic [7:0]  proto_sel;
        logic [15:0] match_port;
        logic [9:0]  match_goal;
    } t_config;

endpackage

@@ rtl/ippf_field_capture.sv @@
// Per-frame header capture: byte offset, EtherType, header length, protocol, ports.
// Depends on ippf_pkg.
`timescale 1ns / 1ps

module ippf_field_capture (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output ippf_pkg::t_frame_info o_info
);
    import ippf_pkg::*;

    logic [15:0] r_offset,     n_offset;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_hdr_words,  n_hdr_words;
    logic [7:0]  r_protocol,   n_protocol;
    logic [15:0] r_src_port,   n_src_port;
    logic [15:0] r_dst_port,   n_dst_port;
    logic [6:0]  port_ofs;
    logic [15:0] ofs_wide;
    logic        active;

    always_comb begin
        n_offset     = r_offset;
        n_ether_type = r_ether_type;
        n_hdr_words  = r_hdr_words;
        n_protocol   = r_protocol;
        n_src_port   = r_src_port;
        n_dst_port   = r_dst_port;
        active       = (r_offset != MAX_FRAME_BYTES);
        if (active) begin
            if (r_offset == OFS_TYPE_HI) begin
                n_ether_type[15:8] = i_byte;
            end else if (r_offset == OFS_TYPE_LO) begin
                n_ether_type[7:0] = i_byte;
            end else if (r_offset == OFS_IHL) begin
                n_hdr_words = i_byte[3:0];
            end
            if (r_offset == OFS_PROTOCOL) begin
                n_protocol = i_byte;
            end
        end
        // The header length captured on this byte already places the ports.
        port_ofs = ETH_HDR_LEN + {1'b0, n_hdr_words, 2'b00};
        ofs_wide = {9'd0, port_ofs};
        if (active) begin
            if (r_offset == ofs_wide) begin
                n_src_port[15:8] = i_byte;
            end else if (r_offset == ofs_wide + 16'd1) begin
                n_src_port[7:0] = i_byte;
            end else if (r_offset == ofs_wide + 16'd2) begin
                n_dst_port[15:8] = i_byte;
            end else if (r_offset == ofs_wide + 16'd3) begin
                n_dst_port[7:0] = i_byte;
            end
            n_offset = r_offset + 16'd1;
        end
    end

    assign o_info.length      = n_offset;
    assign o_info.port_ofs    = port_ofs;
    assign o_info.ether_type  = n_ether_type;
    assign o_info.ip_protocol = n_protocol;
    assign o_info.src_port    = n_src_port;
    assign o_info.dst_port    = n_dst_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_end)) begin
            r_offset     <= '0;
            r_ether_type <= '0;
            r_hdr_words  <= '0;
            r_protocol   <= '0;
            r_src_port   <= '0;
            r_dst_port   <= '0;
        end else if (i_valid) begin
            r_offset     <= n_offset;
            r_ether_type <= n_ether_type;
            r_hdr_words  <= n_hdr_words;
            r_protocol   <= n_protocol;
            r_src_port   <= n_src_port;
            r_dst_port   <= n_dst_port;
        end
    end

endmodule

@@ rtl/ippf_qualify.sv @@
// Frame qualification and match counting at the end of each frame.
// Depends on ippf_pkg.
`timescale 1ns / 1ps

module ippf_qualify (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ippf_pkg::t_frame_info i_info,
    input  ippf_pkg::t_config     i_cfg,
    output ippf_pkg::t_result     o_result
);
    import ippf_pkg::*;

    logic [9:0]  r_count, n_count;
    logic [9:0]  req;
    logic [15:0] ofs_wide;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        pass;
    logic        counted;

    always_comb begin
        ofs_wide = {9'd0, i_info.port_ofs};
        sp  = (i_info.length >= ofs_wide + 16'd2) ? i_info.src_port : 16'd0;
        dp  = (i_info.length >= ofs_wide + 16'd4) ? i_info.dst_port : 16'd0;
        req = (i_cfg.match_goal > MAX_MATCH_COUNT) ? MAX_MATCH_COUNT
                                                   : i_cfg.match_goal;
        pass = (i_info.length >= MIN_FRAME_LEN)
            && (i_info.length >= ofs_wide + 16'd4)
            && (i_info.ether_type == IPV4_ETHERTYPE)
            && (i_info.ip_protocol == i_cfg.proto_sel)
            && ((sp == i_cfg.match_port) || (dp == i_cfg.match_port));
        counted = pass && (r_count < req);
        n_count = counted ? r_count + 10'd1 : r_count;

        o_result.matched      = counted;
        o_result.src_port     = sp;
        o_result.dst_port     = dp;
        o_result.frame_length = i_info.length;
        o_result.match_count  = n_count;
        o_result.done_res     = (n_count >= req);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_valid) begin
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/ipv4_port_packet_filter_unit.sv @@
// A frame's result is held in the result register once its last byte, taken into the input register, moves on.
// Throughput: one byte per cycle; the input register, a single pass of capture
// and qualification logic, and the result register keep bytes flowing back to back.
// The input only stalls when a finished result is still waiting downstream.
// Synchronous active-low reset clears frame state and the match count and
// returns the configuration registers to their reset values.
`timescale 1ns / 1ps

module ipv4_port_packet_filter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_frame_byte,
    input  logic                             i_frame_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ippf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ippf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_matched,
    output logic [15:0]                      o_src_port,
    output logic [15:0]                      o_dst_port,
    output logic [15:0]                      o_frame_length,
    output logic [9:0]                       o_match_count,
    output logic                             o_done_res
);
    import ippf_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    logic        r_out_valid;
    t_result     r_out;
    t_config     r_cfg;
    t_frame_info frame_info;
    t_result     result;
    logic        out_free;
    logic        advance;
    logic        emit;

    // A held byte moves on unless it closes a frame and the result slot is full.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!r_in_end || out_free);
    assign emit     = advance && r_in_end;
    assign o_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proto_sel  <= 8'd6;
            r_cfg.match_port <= 16'd1;
            r_cfg.match_goal <= 10'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROTOCOL:   r_cfg.proto_sel  <= i_cfg_data[7:0];
                CFG_MATCH_PORT: r_cfg.match_port <= i_cfg_data[15:0];
                CFG_MATCH_GOAL: r_cfg.match_goal <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    ippf_field_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_info  (frame_info)
    );

    ippf_qualify u_qualify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (emit),
        .i_info   (frame_info),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_matched      = r_out.matched;
    assign o_src_port     = r_out.src_port;
    assign o_dst_port     = r_out.dst_port;
    assign o_frame_length = r_out.frame_length;
    assign o_match_count  = r_out.match_count;
    assign o_done_res     = r_out.done_res;

endmodule
